>>> rtl/vn_pkg.sv
// Shared constants for the 3D vector normalisation pipeline.
`timescale 1ns / 1ps
`default_nettype none
package vn_pkg;
    localparam int COMP_W_DEF = 32;
    localparam int UNIT_W     = 32;
    localparam int MAG_W      = 32;
    localparam int FRAC_BITS  = 30;
    localparam int DIV_BITS   = FRAC_BITS + 1;
    localparam int OUT_TW     = 3 * UNIT_W + MAG_W;
endpackage
`default_nettype wire

>>> rtl/vn_square_lane.sv
// One lane: absolute value and square of a component, split into partial products.
`timescale 1ns / 1ps
`default_nettype none
module vn_square_lane #(
    parameter int W = 32
) (
    input  wire logic           aclk,
    input  wire logic           adv,
    input  wire logic [W-1:0]   comp,
    output logic [2*W-1:0]      sq,
    output logic [W-1:0]        abs_val,
    output logic                neg
);
    localparam int L = (W + 1) / 2;
    localparam int H = W - L;

    logic           neg_a;
    logic [W-1:0]   abs_a;
    logic [L-1:0]   al;
    logic [H-1:0]   ah;
    logic [2*L-1:0] pll_reg;
    logic [H+L-1:0] plh_reg;
    logic [2*H-1:0] phh_reg;
    logic [W-1:0]   abs1_reg;
    logic           neg1_reg;
    logic [2*W-1:0] sq_next;
    logic [2*W-1:0] sq_reg;
    logic [W-1:0]   abs2_reg;
    logic           neg2_reg;

    assign neg_a = comp[W-1];
    assign abs_a = neg_a ? (~comp + W'(1)) : comp;
    assign al    = abs_a[L-1:0];
    assign ah    = abs_a[W-1:L];

    assign sq_next = ((2*W)'(phh_reg) << (2 * L))
                   + ((2*W)'(plh_reg) << (L + 1))
                   + (2*W)'(pll_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            pll_reg  <= al * al;
            plh_reg  <= ah * al;
            phh_reg  <= ah * ah;
            abs1_reg <= abs_a;
            neg1_reg <= neg_a;
            sq_reg   <= sq_next;
            abs2_reg <= abs1_reg;
            neg2_reg <= neg1_reg;
        end
    end

    assign sq      = sq_reg;
    assign abs_val = abs2_reg;
    assign neg     = neg2_reg;
endmodule
`default_nettype wire

>>> rtl/vn_isqrt.sv
// Pipelined integer square root, one root bit per stage, with side data alongside.
`timescale 1ns / 1ps
`default_nettype none
module vn_isqrt #(
    parameter int W      = 32,
    parameter int SIDE_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              adv,
    input  wire logic [2*W+1:0]    rad,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic [W-1:0]           root,
    output logic [SIDE_W-1:0]      side_out
);
    logic [2*W+1:0]    rem_reg  [W];
    logic [W-1:0]      root_reg [W];
    logic [SIDE_W-1:0] side_reg [W];

    for (genvar k = 0; k < W; k++) begin : g_stage
        localparam int B = W - 1 - k;
        logic [2*W+1:0]    rem_in;
        logic [W-1:0]      root_in;
        logic [SIDE_W-1:0] side_i;
        logic [2*W+1:0]    trial;
        if (k == 0) begin : g_first
            assign rem_in  = rad;
            assign root_in = '0;
            assign side_i  = side_in;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_i  = side_reg[k-1];
        end
        assign trial = ((2*W+2)'(root_in) << (B + 1)) + ((2*W+2)'(1) << (2 * B));
        always_ff @(posedge aclk) begin
            if (adv) begin
                side_reg[k] <= side_i;
                if (rem_in >= trial) begin
                    rem_reg[k]  <= rem_in - trial;
                    root_reg[k] <= root_in | (W'(1) << B);
                end else begin
                    rem_reg[k]  <= rem_in;
                    root_reg[k] <= root_in;
                end
            end
        end
    end

    assign root     = root_reg[W-1];
    assign side_out = side_reg[W-1];
endmodule
`default_nettype wire

>>> rtl/vn_div_lane.sv
// One lane: pipelined restoring division of a component by the length, to signed Q1.30.
`timescale 1ns / 1ps
`default_nettype none
module vn_div_lane #(
    parameter int W = 32
) (
    input  wire logic                       aclk,
    input  wire logic                       adv,
    input  wire logic [W-1:0]               mag,
    input  wire logic [W-1:0]               abs_val,
    input  wire logic                       neg,
    output logic signed [vn_pkg::UNIT_W-1:0] unit
);
    import vn_pkg::*;

    logic [W:0]          r_reg   [DIV_BITS];
    logic [DIV_BITS-1:0] q_reg   [DIV_BITS];
    logic [W-1:0]        d_reg   [DIV_BITS];
    logic                neg_reg [DIV_BITS];
    logic [DIV_BITS-1:0] q_fin;
    logic [UNIT_W-1:0]   q_ext;

    for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
        localparam int B = DIV_BITS - 1 - k;
        logic [W:0]          r_in;
        logic [DIV_BITS-1:0] q_in;
        logic [W-1:0]        d_in;
        logic                n_in;
        logic [W:0]          r_sub;
        logic                take;
        if (k == 0) begin : g_first
            assign r_in = {1'b0, abs_val};
            assign q_in = '0;
            assign d_in = mag;
            assign n_in = neg;
        end else begin : g_rest
            assign r_in = r_reg[k-1];
            assign q_in = q_reg[k-1];
            assign d_in = d_reg[k-1];
            assign n_in = neg_reg[k-1];
        end
        assign take  = r_in >= {1'b0, d_in};
        assign r_sub = take ? (r_in - {1'b0, d_in}) : r_in;
        always_ff @(posedge aclk) begin
            if (adv) begin
                r_reg[k]   <= {r_sub[W-1:0], 1'b0};
                q_reg[k]   <= take ? (q_in | (DIV_BITS'(1) << B)) : q_in;
                d_reg[k]   <= d_in;
                neg_reg[k] <= n_in;
            end
        end
    end

    assign q_fin = q_reg[DIV_BITS-1][DIV_BITS-1] ? (DIV_BITS'(1) << FRAC_BITS)
                                                  : q_reg[DIV_BITS-1];
    assign q_ext = UNIT_W'(q_fin);
    assign unit  = neg_reg[DIV_BITS-1] ? (~q_ext + UNIT_W'(1)) : q_ext;
endmodule
`default_nettype wire

>>> rtl/vector3_normalize.sv
// Top level of the 3D vector normaliser: lanes, merge, square root, division, output.
`timescale 1ns / 1ps
`default_nettype none
// Takes one vector of three signed Q16.16 components per transfer and returns its
// unit vector in signed Q1.30 (truncated toward zero), the truncated Q16.16 length
// and a zero-vector flag (components and length then zero). Fully pipelined: a new
// transfer is taken every clock while the output is not stalled; data passes through
// the squaring lanes, the sum, the square root, the dividers and an output register.
// The whole pipeline holds while a result waits on m_axis_tready.
module vector3_normalize #(
    parameter int COMPONENT_WIDTH = vn_pkg::COMP_W_DEF
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    s_axis_tvalid,
    output logic                                         s_axis_tready,
    // comp_x, comp_y, comp_z (COMPONENT_WIDTH each), zero fill to bytes
    input  wire logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
    output logic                                         m_axis_tvalid,
    input  wire logic                                    m_axis_tready,
    // unit_x, unit_y, unit_z, magnitude
    output logic [vn_pkg::OUT_TW-1:0]                    m_axis_tdata,
    // zero_vector
    output logic                                         m_axis_tuser
);
    import vn_pkg::*;

    localparam int W      = COMPONENT_WIDTH;
    localparam int SIDE_W = 3 * W + 4;
    localparam int LAT    = 2 + 1 + W + DIV_BITS;

    logic              adv;
    logic [LAT-1:0]    vld_reg;
    logic [2*W-1:0]    sq   [3];
    logic [W-1:0]      absv [3];
    logic              negv [3];
    logic [2*W+1:0]    sum_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [SIDE_W-1:0] side_sq;
    logic [W-1:0]      root;
    logic [W-1:0]      mag_d_reg [DIV_BITS];
    logic              zero_d_reg [DIV_BITS];
    logic signed [UNIT_W-1:0] unit [3];
    logic [W+31:0]     mag_ext;
    logic [MAG_W-1:0]  mag_sat;
    logic              zero_f;
    logic [OUT_TW-1:0] out_data_next;
    logic [OUT_TW-1:0] out_data_reg;
    logic              out_zero_reg;
    logic              out_vld_reg;

    assign adv           = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = adv;

    for (genvar i = 0; i < 3; i++) begin : g_lane
        vn_square_lane #(.W(W)) u_sq (
            .aclk    (aclk),
            .adv     (adv),
            .comp    (s_axis_tdata[i*W +: W]),
            .sq      (sq[i]),
            .abs_val (absv[i]),
            .neg     (negv[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_reg  <= (2*W+2)'(sq[0]) + (2*W+2)'(sq[1]) + (2*W+2)'(sq[2]);
            side_reg <= {1'b0, negv[2], negv[1], negv[0], absv[2], absv[1], absv[0]};
        end
    end

    vn_isqrt #(.W(W), .SIDE_W(SIDE_W)) u_sqrt (
        .aclk     (aclk),
        .adv      (adv),
        .rad      (sum_reg),
        .side_in  ({sum_reg == '0, side_reg[SIDE_W-2:0]}),
        .root     (root),
        .side_out (side_sq)
    );

    for (genvar i = 0; i < 3; i++) begin : g_div
        vn_div_lane #(.W(W)) u_div (
            .aclk    (aclk),
            .adv     (adv),
            .mag     (root),
            .abs_val (side_sq[i*W +: W]),
            .neg     (side_sq[3*W + i]),
            .unit    (unit[i])
        );
    end

    for (genvar k = 0; k < DIV_BITS; k++) begin : g_dly
        always_ff @(posedge aclk) begin
            if (adv) begin
                mag_d_reg[k]  <= (k == 0) ? root : mag_d_reg[(k == 0) ? 0 : k-1];
                zero_d_reg[k] <= (k == 0) ? side_sq[SIDE_W-1]
                                          : zero_d_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign zero_f  = zero_d_reg[DIV_BITS-1];
    assign mag_ext = (W+32)'(mag_d_reg[DIV_BITS-1]);
    assign mag_sat = ((mag_ext >> MAG_W) != '0) ? '1 : mag_ext[MAG_W-1:0];
    assign out_data_next = zero_f ? '0 : {mag_sat, unit[2], unit[1], unit[0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[LAT-2:0], s_axis_tvalid};
            out_vld_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_data_reg <= out_data_next;
            out_zero_reg <= zero_f;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_zero_reg;

    a_zero_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("zero vector result not cleared");

    a_mag_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[OUT_TW-1 -: MAG_W] != '0)
        else $error("nonzero vector with zero length");

    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> ($signed(m_axis_tdata[UNIT_W-1:0]) <= (1 <<< FRAC_BITS)
                       && $signed(m_axis_tdata[UNIT_W-1:0]) >= -(1 <<< FRAC_BITS)))
        else $error("unit component out of range");
endmodule
`default_nettype wire
